// ===== design/scr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scr_pkg
// shared types and constants for the small component removal block
// ----------------------------------------------------------------------------
package scr_pkg;
  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;
  localparam int unsigned Depth     = MaxWidth * MaxHeight;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned ColW      = $clog2(MaxWidth) + 1;
  localparam int unsigned RowW      = $clog2(MaxHeight) + 1;
  localparam int unsigned AreaW     = 19;
  localparam int unsigned DimW      = 10;
  localparam logic [7:0]  KeepValue = 8'd255;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegArea   = 2'd2;

  typedef enum logic [0:0] {
    ReqLoad  = 1'b0,
    ReqDrain = 1'b1
  } req_e;

  typedef struct packed {
    logic             drain;
    logic [7:0]       pix;
    logic             last;
  } cmd_t;

  typedef enum logic [4:0] {
    StIdle, StInit, StScanRd, StScanChk, StNbRd, StNbChk,
    StFindA, StFindAW, StFindB, StFindBW, StJoinRd, StJoinW,
    StJoinW2, StOutRd, StOutFind, StOutFindW, StOutArea, StOutArea2, StOutWr,
    StDrainRd, StDrainOut
  } st_e;
endpackage
`default_nettype wire

// ===== design/scr_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scr_cmd_fifo
// short queue of accepted commands between front end and engine
// ----------------------------------------------------------------------------
module scr_cmd_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  scr_pkg::cmd_t        push_data_i,
  input  wire                  pop_i,
  output scr_pkg::cmd_t        pop_data_o,
  output logic                 empty_o,
  output logic                 full_o
);
  import scr_pkg::*;
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  assign pop_data_o = mem_q[rp_q];
  assign empty_o    = (cnt_q == 2'd0);
  assign full_o     = (cnt_q == 2'd2);
endmodule
`default_nettype wire

// ===== design/scr_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scr_engine
// stores the mask, labels components with union-find, serves drains
// ----------------------------------------------------------------------------
module scr_engine (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cmd_valid_i,
  input  scr_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  input  wire  [scr_pkg::DimW-1:0]    width_i,
  input  wire  [scr_pkg::DimW-1:0]    height_i,
  input  wire  [scr_pkg::AreaW-1:0]   min_area_i,
  output logic                        res_valid_o,
  output logic [7:0]                  res_pixel_o,
  output logic                        res_last_o
);
  import scr_pkg::*;

  logic [7:0]       pix_mem  [Depth];
  logic [IdxW-1:0]  par_mem  [Depth];
  logic [AreaW-1:0] area_mem [Depth];

  st_e st_q, st_d;
  logic [CntW-1:0]  load_q, load_d, drain_q, drain_d, n_q, n_d, i_q, i_d;
  logic             rdy_q, rdy_d;
  logic [ColW-1:0]  w_q, w_d, c_q, c_d;
  logic [RowW-1:0]  r_q, r_d;
  logic [AreaW-1:0] thr_q, thr_d;
  logic [1:0]       nb_q, nb_d;
  logic [IdxW-1:0]  x_q, x_d, ra_q, ra_d, rb_q, rb_d;
  logic [AreaW-1:0] aa_q, aa_d;

  // memory ports
  logic             pw_en, parw_en, aw_en;
  logic [IdxW-1:0]  pw_a, pr_a, parw_a, parr_a, aw_a, ar_a;
  logic [7:0]       pw_d, pr_q;
  logic [IdxW-1:0]  parw_d, parr_q;
  logic [AreaW-1:0] aw_d, ar_q;

  always_ff @(posedge clk_i) begin
    if (pw_en) pix_mem[pw_a] <= pw_d;
    pr_q <= pix_mem[pr_a];
    if (parw_en) par_mem[parw_a] <= parw_d;
    parr_q <= par_mem[parr_a];
    if (aw_en) area_mem[aw_a] <= aw_d;
    ar_q <= area_mem[ar_a];
  end

  logic [ColW-1:0] wc;
  logic [RowW-1:0] hc;
  always_comb begin
    wc = (width_i == '0) ? ColW'(1) : (width_i > DimW'(MaxWidth)) ? ColW'(MaxWidth)
         : ColW'(width_i);
    hc = (height_i == '0) ? RowW'(1) : (height_i > DimW'(MaxHeight)) ? RowW'(MaxHeight)
         : RowW'(height_i);
  end

  logic [CntW-1:0] nprod;
  assign nprod = CntW'(wc * hc);

  logic [IdxW-1:0] cur, nb_a;
  logic            nb_ok;
  assign cur = i_q[IdxW-1:0];
  always_comb begin
    nb_a  = cur;
    nb_ok = 1'b0;
    case (nb_q)
      2'd0: begin nb_a = cur - IdxW'(1); nb_ok = (c_q != '0); end
      2'd1: begin nb_a = cur - IdxW'(w_q); nb_ok = (r_q != '0); end
      2'd2: begin nb_a = cur - IdxW'(w_q) - IdxW'(1); nb_ok = (r_q != '0) && (c_q != '0); end
      default: begin
        nb_a  = cur - IdxW'(w_q) + IdxW'(1);
        nb_ok = (r_q != '0) && (c_q + ColW'(1) < w_q);
      end
    endcase
  end

  always_comb begin
    st_d = st_q; load_d = load_q; drain_d = drain_q; n_d = n_q; i_d = i_q;
    rdy_d = rdy_q; w_d = w_q; c_d = c_q; r_d = r_q; thr_d = thr_q; nb_d = nb_q;
    x_d = x_q; ra_d = ra_q; rb_d = rb_q; aa_d = aa_q;
    pw_en = 1'b0; pw_a = cur; pw_d = '0; pr_a = cur;
    parw_en = 1'b0; parw_a = cur; parw_d = cur; parr_a = x_q;
    aw_en = 1'b0; aw_a = cur; aw_d = AreaW'(1); ar_a = ra_q;
    cmd_pop_o = 1'b0; res_valid_o = 1'b0; res_pixel_o = pr_q; res_last_o = 1'b0;
    case (st_q)
      StIdle: if (cmd_valid_i) begin
        cmd_pop_o = 1'b1;
        if (cmd_i.drain == ReqLoad) begin
          rdy_d = 1'b0;
          if (load_q < nprod) begin
            pw_en = 1'b1; pw_a = load_q[IdxW-1:0]; pw_d = cmd_i.pix;
            load_d = load_q + CntW'(1);
          end
          if (cmd_i.last) begin
            load_d = '0; drain_d = '0; n_d = nprod; w_d = wc; thr_d = min_area_i;
            i_d = '0; c_d = '0; r_d = '0;
            st_d = (min_area_i == '0) ? StIdle : StInit;
            rdy_d = (min_area_i == '0);
          end
        end else if (rdy_q && drain_q < n_q) begin
          pr_a = drain_q[IdxW-1:0];
          st_d = StDrainRd;
        end
      end
      StDrainRd: begin pr_a = drain_q[IdxW-1:0]; st_d = StDrainOut; end
      StDrainOut: begin
        res_valid_o = 1'b1;
        if (drain_q + CntW'(1) == n_q) begin
          res_last_o = 1'b1; rdy_d = 1'b0; drain_d = '0;
        end else drain_d = drain_q + CntW'(1);
        st_d = StIdle;
      end
      StInit: begin
        parw_en = 1'b1; aw_en = 1'b1;
        if (i_q + CntW'(1) == n_q) begin i_d = '0; st_d = StScanRd; end
        else i_d = i_q + CntW'(1);
      end
      StScanRd: begin pr_a = cur; st_d = StScanChk; end
      StScanChk: begin
        nb_d = 2'd0;
        st_d = (pr_q != '0) ? StNbRd : StNbChk;
        if (pr_q == '0) nb_d = 2'd3;
      end
      StNbRd: begin pr_a = nb_a; st_d = StNbChk; end
      StNbChk: begin
        if (nb_ok && pr_q != '0) begin
          x_d = cur; rb_d = nb_a; st_d = StFindA;
        end else if (nb_q == 2'd3) begin
          if (i_q + CntW'(1) == n_q) begin i_d = '0; st_d = StOutRd; end
          else begin
            i_d = i_q + CntW'(1);
            if (c_q + ColW'(1) == w_q) begin c_d = '0; r_d = r_q + RowW'(1); end
            else c_d = c_q + ColW'(1);
            st_d = StScanRd;
          end
        end else begin nb_d = nb_q + 2'd1; st_d = StNbRd; end
      end
      StFindA: begin parr_a = x_q; st_d = StFindAW; end
      StFindAW: begin
        if (parr_q == x_q) begin ra_d = x_q; x_d = rb_q; st_d = StFindB; end
        else begin x_d = parr_q; st_d = StFindA; end
      end
      StFindB: begin parr_a = x_q; st_d = StFindBW; end
      StFindBW: begin
        if (parr_q == x_q) begin
          rb_d = x_q;
          st_d = (x_q == ra_q) ? StJoinW2 : StJoinRd;
        end else begin x_d = parr_q; st_d = StFindB; end
      end
      StJoinRd: begin ar_a = ra_q; st_d = StJoinW; end
      StJoinW: begin aa_d = ar_q; ar_a = rb_q; st_d = StOutArea2; end
      StOutArea2: begin
        if (aa_q < ar_q) begin
          parw_en = 1'b1; parw_a = ra_q; parw_d = rb_q;
          aw_en = 1'b1; aw_a = rb_q; aw_d = aa_q + ar_q;
        end else begin
          parw_en = 1'b1; parw_a = rb_q; parw_d = ra_q;
          aw_en = 1'b1; aw_a = ra_q; aw_d = aa_q + ar_q;
        end
        st_d = StJoinW2;
      end
      StJoinW2: begin
        if (nb_q == 2'd3) begin
          if (i_q + CntW'(1) == n_q) begin i_d = '0; st_d = StOutRd; end
          else begin
            i_d = i_q + CntW'(1);
            if (c_q + ColW'(1) == w_q) begin c_d = '0; r_d = r_q + RowW'(1); end
            else c_d = c_q + ColW'(1);
            st_d = StScanRd;
          end
        end else begin nb_d = nb_q + 2'd1; st_d = StNbRd; end
      end
      StOutRd: begin pr_a = cur; x_d = cur; st_d = StOutFind; end
      StOutFind: begin
        if (pr_q == '0) st_d = StOutWr;
        else begin parr_a = x_q; st_d = StOutFindW; end
      end
      StOutFindW: begin
        if (parr_q == x_q) begin ar_a = x_q; st_d = StOutArea; end
        else begin x_d = parr_q; parr_a = parr_q; st_d = StOutFindW; end
      end
      StOutArea: begin aa_d = ar_q; st_d = StOutWr; end
      StOutWr: begin
        pw_en = 1'b1; pw_a = cur;
        pw_d = (pr_q != '0 && aa_q >= thr_q) ? KeepValue : 8'd0;
        aa_d = '0;
        if (i_q + CntW'(1) == n_q) begin rdy_d = 1'b1; st_d = StIdle; end
        else begin i_d = i_q + CntW'(1); st_d = StOutRd; end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; load_q <= '0; drain_q <= '0; rdy_q <= 1'b0; n_q <= '0;
    end else begin
      st_q <= st_d; load_q <= load_d; drain_q <= drain_d; rdy_q <= rdy_d; n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; w_q <= w_d; c_q <= c_d; r_q <= r_d; thr_q <= thr_d; nb_q <= nb_d;
    x_q <= x_d; ra_q <= ra_d; rb_q <= rb_d; aa_q <= aa_d;
  end
endmodule
`default_nettype wire

// ===== design/small_component_removal.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// small_component_removal
// area filter on 8-connected components of a byte mask
// ----------------------------------------------------------------------------
// Commands pass through a two-entry queue; busy is high only while it is full.
// The engine takes one load per cycle while idle. The frame-ending load starts
// labeling, during which queued commands wait: an init pass over every pixel,
// a raster scan that checks up to four earlier neighbors of each set pixel,
// with a union-find walk to both roots and a join by area when they differ,
// then a rewrite pass that walks each set pixel to its root and keeps it if
// its component area reaches min_area. A drain reads one stored pixel; its
// result is on result_valid_o for one cycle and the receiver cannot stall it.
// Passthrough (min_area zero) skips labeling.
module small_component_removal (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire                         req_type_i,
  input  wire  [7:0]                  pixel_value_i,
  input  wire                         last_pixel_i,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [1:0]                  cfg_index_i,
  input  wire  [18:0]                 cfg_data_i,
  output logic                        result_valid_o,
  output logic [7:0]                  result_pixel_o,
  output logic                        last_result_o
);
  import scr_pkg::*;

  logic [DimW-1:0]  width_q, height_q;
  logic [AreaW-1:0] area_q;
  cmd_t cin, cout;
  logic empty, full, pop;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(512);
      height_q <= DimW'(512);
      area_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i[DimW-1:0];
        RegHeight: height_q <= cfg_data_i[DimW-1:0];
        RegArea:   area_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = full;
  assign cin  = '{drain: req_type_i, pix: pixel_value_i, last: last_pixel_i};

  scr_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(start && !full), .push_data_i(cin),
    .pop_i(pop), .pop_data_o(cout), .empty_o(empty), .full_o(full)
  );

  scr_engine u_eng (
    .clk_i, .rst_ni, .cmd_valid_i(!empty), .cmd_i(cout), .cmd_pop_o(pop),
    .width_i(width_q), .height_i(height_q), .min_area_i(area_q),
    .res_valid_o(result_valid_o), .res_pixel_o(result_pixel_o),
    .res_last_o(last_result_o)
  );
endmodule
`default_nettype wire

// ===== design/scr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scr_checker
// port-level checks for small component removal
// ----------------------------------------------------------------------------
module scr_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       start,
  input wire       busy,
  input wire       result_valid_o,
  input wire       last_result_o,
  input wire [7:0] result_pixel_o
);
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |-> result_valid_o) else $error("last without result");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back to back result");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown({result_pixel_o, last_result_o}))
    else $error("unknown result");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without transfer");
endmodule

bind small_component_removal scr_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .last_result_o, .result_pixel_o
);
`default_nettype wire
